// ----- rtl/tfb_pkg.sv -----
// Shared types and constants of the TLV frame builder with CRC-16.
// No dependencies; every other file of the block imports this package.
package tfb_pkg;

	// Fixed frame overhead: header, tag, length and two CRC bytes
	localparam logic [7:0] FIXED_BYTES = 8'd5;
	localparam logic [7:0] TEMP_LEN = FIXED_BYTES + 8'd2;
	localparam logic [7:0] TIME_LEN = FIXED_BYTES + 8'd6;

	// Frame bytes that enter the CRC in the longest item (time frame)
	localparam int CMD_BYTES = 9;
	localparam int CMD_CNT_W = $clog2(CMD_BYTES + 1);

	// Reciprocal of 100 scaled by 2**19, rounded down
	localparam logic [12:0] DIV100_RECIP = 13'd5242;
	localparam int DIV100_SHIFT = 19;

	// CRC-ITU-T polynomial, non-reflected
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_TAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TAG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_TAG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd5;
	localparam int CFG_DATA_W = 16;

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_SERIAL = 2'd0,
		FUNC_TEMP   = 2'd1,
		FUNC_TIME   = 2'd2,
		FUNC_UNUSED = 2'd3
	} tfb_func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic [7:0]  serial_length;
		logic [15:0] temperature;
		logic [8:0]  year_since_1900;
		logic [3:0]  month_index;
		logic [4:0]  day_of_month;
		logic [4:0]  hour_of_day;
		logic [5:0]  minute_of_hour;
		logic [5:0]  second_of_minute;
	} tfb_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_last;
		logic       frame_error;
		logic [7:0] frame_total;
	} tfb_out_t;

	typedef struct packed {
		logic [7:0]  header_byte;
		logic [7:0]  serial_tag;
		logic [7:0]  temperature_tag;
		logic [7:0]  time_tag;
		logic [15:0] crc_seed;
		logic [7:0]  frame_capacity;
	} tfb_cfg_t;

	// One queued job for the emitter: CRC-covered bytes, then optional tail
	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] bytes;
		logic [CMD_CNT_W-1:0]      nbytes;
		logic                      seed;
		logic                      serial;
		logic                      tail;
		logic                      err;
		logic [7:0]                total;
	} tfb_cmd_t;

endpackage

// ----- rtl/tlv_frame_builder_crc16_unit.sv -----
// Top level of the TLV frame builder with CRC-16: configuration registers,
// front end, job queue and emitter. Uses tfb_pkg, tfb_front, tfb_queue, tfb_back.
//
// Input channel (in_valid / in_stall / in_item): one item per accepted beat;
// func selects a serial-number byte, a temperature or a time item.
// Output channel (out_valid / out_stall / out_item): one frame byte per beat,
// header, tag, length, payload, then CRC high and low byte; frame_last marks
// the final byte, frame_error a rejected item (capacity too small).
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while the block is idle.
// With the queue empty, an accepted item passes the front-end stage register
// and the job queue before out_valid rises for its first byte.
// Throughput: the emitter sends one byte per cycle while the output is not
// stalled; a time item makes 11 bytes, a temperature item 7, a mid-string
// serial byte 1 and an error 1. Items enter one per cycle while the
// job queue (QueueDepth entries) has room.
// Reset clears the serial position, the queue and the output valid, and loads
// the register defaults. A stalled output holds its byte; the queue keeps
// taking items until full, then in_stall rises.
module tlv_frame_builder_crc16_unit #(
	parameter int QueueDepth = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tfb_pkg::tfb_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tfb_pkg::tfb_out_t              out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tfb_pkg::*;

	tfb_cfg_t cfg_q;
	logic     push;
	tfb_cmd_t push_cmd;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	tfb_cmd_t head_cmd;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte     <= 8'd0;
			cfg_q.serial_tag      <= 8'd1;
			cfg_q.temperature_tag <= 8'd2;
			cfg_q.time_tag        <= 8'd3;
			cfg_q.crc_seed        <= 16'hFFFF;
			cfg_q.frame_capacity  <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER:     cfg_q.header_byte     <= cfg_data[7:0];
				CFG_SERIAL_TAG: cfg_q.serial_tag      <= cfg_data[7:0];
				CFG_TEMP_TAG:   cfg_q.temperature_tag <= cfg_data[7:0];
				CFG_TIME_TAG:   cfg_q.time_tag        <= cfg_data[7:0];
				CFG_CRC_SEED:   cfg_q.crc_seed        <= cfg_data;
				CFG_CAPACITY:   cfg_q.frame_capacity  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	tfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	tfb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/tfb_front.sv -----
// Front end of the TLV frame builder: accepts items, tracks the serial
// string position and turns each item into an emitter job. Uses tfb_pkg.
module tfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tfb_pkg::tfb_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  tfb_pkg::tfb_in_t  in_item,
	output logic              push,
	output tfb_pkg::tfb_cmd_t push_cmd,
	input  logic              q_full
);
	import tfb_pkg::*;

	logic        valid_s1;
	tfb_in_t     item_s1;
	logic [9:0]  quot_s1;
	logic [7:0]  serial_count_q;
	logic [7:0]  serial_kept_q;

	logic [28:0] quot_prod;
	logic        advance;
	logic        want_push;
	logic [7:0]  count_next;
	logic [7:0]  kept_next;
	tfb_cmd_t    cmd;

	// Hold the stage while the queue is full
	assign advance  = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;

	// Estimate temperature / 100; may be one low, fixed in the next stage
	assign quot_prod = 29'(in_item.temperature) * 29'(DIV100_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
			quot_s1 <= quot_prod[28:DIV100_SHIFT];
		end
	end

	// Build the job and the next serial state
	always_comb begin
		logic [15:0] rem_raw;
		logic        rem_ge;
		logic [7:0]  rem_fix;
		logic [9:0]  quot_fix;
		logic        open;
		logic [7:0]  room;
		logic [7:0]  len;
		logic [7:0]  kept_eff;
		logic        has_data;
		logic [7:0]  cnt_inc;

		rem_raw  = item_s1.temperature - 16'({6'd0, quot_s1} * 16'd100);
		rem_ge   = rem_raw[7:0] >= 8'd100;
		rem_fix  = rem_ge ? rem_raw[7:0] - 8'd100 : rem_raw[7:0];
		quot_fix = quot_s1 + {9'd0, rem_ge};

		len      = item_s1.serial_length;
		open     = serial_count_q == 8'd0;
		room     = (cfg.frame_capacity >= FIXED_BYTES) ?
			cfg.frame_capacity - FIXED_BYTES : 8'd0;
		kept_eff = open ? ((len < room) ? len : room) : serial_kept_q;
		has_data = serial_count_q < kept_eff;
		cnt_inc  = serial_count_q + 8'd1;

		cmd        = '0;
		want_push  = 1'b0;
		count_next = serial_count_q;
		kept_next  = serial_kept_q;

		case (tfb_func_t'(item_s1.func))
			FUNC_SERIAL: begin
				kept_next  = kept_eff;
				count_next = (cnt_inc >= len) ? 8'd0 : cnt_inc;
				cmd.seed   = open;
				cmd.serial = 1'b1;
				cmd.total  = kept_eff + FIXED_BYTES;
				cmd.tail   = (kept_eff == 8'd0 && open) ||
					(kept_eff != 8'd0 && ({1'b0, serial_count_q} + 9'd1) ==
					{1'b0, kept_eff});
				if (open) begin
					cmd.bytes[0] = cfg.header_byte;
					cmd.bytes[1] = cfg.serial_tag;
					cmd.bytes[2] = kept_eff + FIXED_BYTES;
					cmd.bytes[3] = item_s1.data_byte;
					cmd.nbytes   = has_data ? CMD_CNT_W'(4) : CMD_CNT_W'(3);
				end else begin
					cmd.bytes[0] = item_s1.data_byte;
					cmd.nbytes   = has_data ? CMD_CNT_W'(1) : CMD_CNT_W'(0);
				end
				want_push = open || has_data;
			end
			FUNC_TEMP: begin
				want_push = 1'b1;
				if (cfg.frame_capacity < TEMP_LEN) begin
					cmd.err = 1'b1;
				end else begin
					cmd.bytes[0] = cfg.header_byte;
					cmd.bytes[1] = cfg.temperature_tag;
					cmd.bytes[2] = TEMP_LEN;
					cmd.bytes[3] = quot_fix[7:0];
					cmd.bytes[4] = rem_fix;
					cmd.nbytes   = CMD_CNT_W'(5);
					cmd.seed     = 1'b1;
					cmd.tail     = 1'b1;
					cmd.total    = TEMP_LEN;
				end
			end
			FUNC_TIME: begin
				want_push = 1'b1;
				if (cfg.frame_capacity < TIME_LEN) begin
					cmd.err = 1'b1;
				end else begin
					cmd.bytes[0] = cfg.header_byte;
					cmd.bytes[1] = cfg.time_tag;
					cmd.bytes[2] = TIME_LEN;
					cmd.bytes[3] = 8'(item_s1.year_since_1900 - 9'd100);
					cmd.bytes[4] = {4'd0, item_s1.month_index} + 8'd1;
					cmd.bytes[5] = {3'd0, item_s1.day_of_month};
					cmd.bytes[6] = {3'd0, item_s1.hour_of_day};
					cmd.bytes[7] = {2'd0, item_s1.minute_of_hour};
					cmd.bytes[8] = {2'd0, item_s1.second_of_minute};
					cmd.nbytes   = CMD_CNT_W'(9);
					cmd.seed     = 1'b1;
					cmd.tail     = 1'b1;
					cmd.total    = TIME_LEN;
				end
			end
			default: begin
				want_push = 1'b0;
			end
		endcase
	end

	assign push     = advance && want_push;
	assign push_cmd = cmd;

	// Advance the serial string position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_count_q <= 8'd0;
			serial_kept_q  <= 8'd0;
		end else if (advance) begin
			serial_count_q <= count_next;
			serial_kept_q  <= kept_next;
		end
	end

endmodule

// ----- rtl/tfb_queue.sv -----
// Job queue between front end and emitter of the TLV frame builder.
// Small register FIFO of tfb_pkg::tfb_cmd_t entries.
module tfb_queue #(
	parameter int Depth = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tfb_pkg::tfb_cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output tfb_pkg::tfb_cmd_t head_cmd
);
	import tfb_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	tfb_cmd_t        slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = count_q == CntW'(Depth);
	assign empty    = count_q == '0;
	assign head_cmd = slot_q[rd_ptr_q];

	// Store jobs
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- rtl/tfb_back.sv -----
// Emitter of the TLV frame builder: walks each queued job one frame byte
// per cycle while the output is not stalled, runs the CRC-16 and drives the output register. Uses tfb_pkg.
module tfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tfb_pkg::tfb_cfg_t cfg,
	input  logic              q_empty,
	input  tfb_pkg::tfb_cmd_t head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output tfb_pkg::tfb_out_t out_item
);
	import tfb_pkg::*;

	// One byte of CRC-ITU-T, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'd0};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	logic [CMD_CNT_W-1:0] pos_q;
	logic [15:0]          crc_q;
	logic [15:0]          serial_crc_q;
	logic                 out_valid_q;
	tfb_out_t             out_item_q;

	logic                 emit;
	logic [CMD_CNT_W:0]   pos_ext;
	logic [CMD_CNT_W:0]   n_ext;
	logic                 is_data;
	logic                 is_hi;
	logic                 last_step;
	logic [15:0]          crc_run;
	logic [15:0]          crc_cur;
	logic [7:0]           data_sel;
	tfb_out_t             next_item;

	assign emit    = !q_empty && (!out_valid_q || !out_stall);
	assign pos_ext = {1'b0, pos_q};
	assign n_ext   = {1'b0, head_cmd.nbytes};

	// Classify the current step of the job
	assign is_data   = !head_cmd.err && (pos_q < head_cmd.nbytes);
	assign is_hi     = !head_cmd.err && head_cmd.tail && (pos_q == head_cmd.nbytes);
	assign last_step = head_cmd.err ||
		(head_cmd.tail ? (pos_ext == n_ext + (CMD_CNT_W+1)'(1)) :
		(pos_ext + (CMD_CNT_W+1)'(1) == n_ext));
	// Serial frames keep their own running CRC across interleaved items
	assign crc_run   = head_cmd.serial ? serial_crc_q : crc_q;
	assign crc_cur   = (head_cmd.seed && pos_q == '0) ? cfg.crc_seed : crc_run;
	assign data_sel  = (pos_q < CMD_CNT_W'(CMD_BYTES)) ?
		head_cmd.bytes[pos_q] : 8'd0;

	always_comb begin
		next_item             = '0;
		next_item.frame_error = head_cmd.err;
		if (head_cmd.err) begin
			next_item.frame_last = 1'b1;
		end else if (is_data) begin
			next_item.out_byte = data_sel;
		end else if (is_hi) begin
			next_item.out_byte = crc_cur[15:8];
		end else begin
			next_item.out_byte    = crc_cur[7:0];
			next_item.frame_last  = 1'b1;
			next_item.frame_total = head_cmd.total;
		end
	end

	assign pop = emit && last_step;

	// Step through the job and run the CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			crc_q        <= 16'd0;
			serial_crc_q <= 16'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				pos_q <= last_step ? '0 : pos_q + CMD_CNT_W'(1);
				if (is_data) begin
					if (head_cmd.serial) begin
						serial_crc_q <= crc_byte(crc_cur, data_sel);
					end else begin
						crc_q <= crc_byte(crc_cur, data_sel);
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q <= next_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
